### src/rfltm_pkg.sv
`timescale 1ns / 1ps

package rfltm_pkg;

  localparam logic [7:0] HDR_BYTE0 = 8'hAB;
  localparam logic [7:0] HDR_BYTE1 = 8'hCD;
  localparam logic [7:0] CRC_POLY  = 8'h31;
  localparam logic [7:0] CRC_INIT  = 8'hFF;

  // frame byte positions
  localparam int unsigned POS_HDR0    = 0;
  localparam int unsigned POS_HDR1    = 1;
  localparam int unsigned POS_PAY_LO  = 2;
  localparam int unsigned POS_PAY_HI  = 9;
  localparam int unsigned POS_CRC     = 10;
  localparam int unsigned PAY_BYTES   = 8;

  localparam logic [9:0]  THR_CLAMP   = 10'd1000;
  localparam logic [10:0] THR_SAT     = 11'd2047;

  localparam logic [15:0] TIMEOUT_RST = 16'd100;
  localparam logic [5:0]  MIN_THR_RST = 6'd48;

  localparam int unsigned CFG_AW = 4;

  typedef enum logic [1:0] {
    REG_ARMED   = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_MIN_THR = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    FST_NONE = 2'd0,
    FST_GOOD = 2'd1,
    FST_BAD  = 2'd2
  } frame_st_t;

  typedef logic [10:0]         thr_t;
  typedef thr_t [3:0]          thr_arr_t;
  typedef logic [PAY_BYTES*8-1:0] payload_t;

  typedef struct packed {
    logic        armed;
    logic [15:0] link_timeout_ms;
    logic [5:0]  min_throttle;
  } cfg_t;

  typedef struct packed {
    logic     done;
    logic     good;
    payload_t payload;
  } frame_res_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### src/rc_frame_link_throttle_map_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_command, in_rx_byte, in_now_ms
// out       output     out_valid / out_stall throttles, strobe, link, status, intervals
// cfg       input      psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// One transaction per cycle sustained while out_stall is low.
// Item goes through an input register, then frame/link logic into the result register.
// Reset (rst_n low, synchronous) clears link state, throttles, interval max; sets interval min to ones; no clear pass.
// out_stall holds the result register; the input register stalls behind it while full.

module rc_frame_link_throttle_map_top #(
  parameter int unsigned FRAME_BYTES = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [7:0]                   in_rx_byte,
  input  logic [31:0]                  in_now_ms,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [10:0]                  out_throttle_0,
  output logic [10:0]                  out_throttle_1,
  output logic [10:0]                  out_throttle_2,
  output logic [10:0]                  out_throttle_3,
  output logic                         out_write_strobe,
  output logic                         out_link_up,
  output logic [1:0]                   out_frame_status,
  output logic [31:0]                  out_interval_min,
  output logic [31:0]                  out_interval_max,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rfltm_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  rfltm_pkg::cfg_t        cfg;
  rfltm_pkg::frame_res_t  frm;
  rfltm_pkg::thr_arr_t    mapped;

  // input register
  logic        s1_valid_r;
  logic        s1_cmd_r;
  logic [7:0]  s1_byte_r;
  logic [31:0] s1_now_r;
  logic        advance;

  // link state
  logic                 connected_r, connected_nxt;
  logic                 fresh_r, fresh_nxt;
  logic [31:0]          last_good_r, last_good_nxt;
  logic [31:0]          imin_r, imin_nxt;
  logic [31:0]          imax_r, imax_nxt;
  rfltm_pkg::thr_arr_t  thr_r, thr_nxt;
  rfltm_pkg::payload_t  latched_r, latched_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 strobe_r, strobe_nxt;
  rfltm_pkg::frame_st_t status_r, status_nxt;

  logic [31:0] elapsed;
  logic        conn_tick;

  rfltm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rfltm_frame_rx #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_frame_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (advance && !s1_cmd_r),
    .rx_byte (s1_byte_r),
    .frm     (frm)
  );

  rfltm_map u_map (
    .payload      (latched_r),
    .min_throttle (cfg.min_throttle),
    .thr          (mapped)
  );

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd_r  <= in_command;
      s1_byte_r <= in_rx_byte;
      s1_now_r  <= in_now_ms;
    end
  end

  assign elapsed   = s1_now_r - last_good_r;
  assign conn_tick = connected_r && !(elapsed > 32'(cfg.link_timeout_ms));

  always_comb begin
    connected_nxt = connected_r;
    fresh_nxt     = fresh_r;
    last_good_nxt = last_good_r;
    imin_nxt      = imin_r;
    imax_nxt      = imax_r;
    thr_nxt       = thr_r;
    latched_nxt   = latched_r;
    strobe_nxt    = 1'b0;
    status_nxt    = rfltm_pkg::FST_NONE;
    if (!s1_cmd_r) begin
      if (frm.done) begin
        status_nxt = frm.good ? rfltm_pkg::FST_GOOD : rfltm_pkg::FST_BAD;
        if (!connected_r) begin
          if (frm.good) begin
            latched_nxt   = frm.payload;
            last_good_nxt = s1_now_r;
            connected_nxt = 1'b1;
          end
        end else if (frm.good) begin
          latched_nxt   = frm.payload;
          fresh_nxt     = 1'b1;
          last_good_nxt = s1_now_r;
          if (elapsed > imax_r) imax_nxt = elapsed;
          if (elapsed < imin_r) imin_nxt = elapsed;
        end else begin
          connected_nxt = 1'b0;
        end
      end
    end else begin
      connected_nxt = conn_tick;
      if (conn_tick && cfg.armed) begin
        if (fresh_r) begin
          fresh_nxt  = 1'b0;
          thr_nxt    = mapped;
          strobe_nxt = 1'b1;
        end
      end else begin
        thr_nxt    = '0;
        strobe_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state moves only with a result load, so it always matches the held result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      connected_r <= 1'b0;
      fresh_r     <= 1'b0;
      last_good_r <= '0;
      imin_r      <= '1;
      imax_r      <= '0;
      thr_r       <= '0;
      strobe_r    <= 1'b0;
      status_r    <= rfltm_pkg::FST_NONE;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        connected_r <= connected_nxt;
        fresh_r     <= fresh_nxt;
        last_good_r <= last_good_nxt;
        imin_r      <= imin_nxt;
        imax_r      <= imax_nxt;
        thr_r       <= thr_nxt;
        strobe_r    <= strobe_nxt;
        status_r    <= status_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      latched_r <= latched_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_throttle_0   = thr_r[0];
  assign out_throttle_1   = thr_r[1];
  assign out_throttle_2   = thr_r[2];
  assign out_throttle_3   = thr_r[3];
  assign out_write_strobe = strobe_r;
  assign out_link_up      = connected_r;
  assign out_frame_status = status_r;
  assign out_interval_min = imin_r;
  assign out_interval_max = imax_r;

  a_status_no_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != rfltm_pkg::FST_NONE) |-> !strobe_r)
    else $error("frame status and motor strobe in one transaction");

  a_down_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && strobe_r && !connected_r) |-> (thr_r == '0))
    else $error("strobe with link down carries nonzero throttle");

  a_interval_order: assert property (@(posedge clk) disable iff (!rst_n)
    (imin_r != '1) |-> (imin_r <= imax_r))
    else $error("interval minimum above maximum");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room downstream");

  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (!advance && $past(rst_n)) |=> $stable(connected_r) && $stable(thr_r))
    else $error("link state moved without a result load");

endmodule

### src/rfltm_regs.sv
`timescale 1ns / 1ps

module rfltm_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rfltm_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output rfltm_pkg::cfg_t                cfg
);

  rfltm_pkg::cfg_t  cfg_r;
  rfltm_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = rfltm_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.armed           <= 1'b0;
      cfg_r.link_timeout_ms <= rfltm_pkg::TIMEOUT_RST;
      cfg_r.min_throttle    <= rfltm_pkg::MIN_THR_RST;
    end else if (wr_en) begin
      case (idx)
        rfltm_pkg::REG_ARMED:   cfg_r.armed           <= pwdata[0];
        rfltm_pkg::REG_TIMEOUT: cfg_r.link_timeout_ms <= pwdata[15:0];
        rfltm_pkg::REG_MIN_THR: cfg_r.min_throttle    <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rfltm_pkg::REG_ARMED:   prdata = {31'd0, cfg_r.armed};
      rfltm_pkg::REG_TIMEOUT: prdata = {16'd0, cfg_r.link_timeout_ms};
      rfltm_pkg::REG_MIN_THR: prdata = {26'd0, cfg_r.min_throttle};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

### src/rfltm_frame_rx.sv
`timescale 1ns / 1ps

module rfltm_frame_rx #(
  parameter int unsigned FRAME_BYTES = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   byte_en,
  input  logic [7:0]             rx_byte,
  output rfltm_pkg::frame_res_t  frm
);

  localparam int unsigned POS_W = $clog2(FRAME_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic             crc_ok_r, crc_ok_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [7:0][7:0]  pay_r;
  logic             last_pos, at_hdr0, at_hdr1, at_pay, at_crc;
  logic [POS_W-1:0] pay_off;

  assign last_pos = (pos_r == POS_W'(FRAME_BYTES - 1));
  assign at_hdr0  = (pos_r == POS_W'(rfltm_pkg::POS_HDR0));
  assign at_hdr1  = (pos_r == POS_W'(rfltm_pkg::POS_HDR1));
  assign at_crc   = (pos_r == POS_W'(rfltm_pkg::POS_CRC));
  assign at_pay   = (pos_r >= POS_W'(rfltm_pkg::POS_PAY_LO)) &&
                    (pos_r <= POS_W'(rfltm_pkg::POS_PAY_HI));
  assign pay_off  = pos_r - POS_W'(rfltm_pkg::POS_PAY_LO);

  always_comb begin
    pos_nxt    = last_pos ? '0 : pos_r + POS_W'(1);
    hdr_ok_nxt = hdr_ok_r;
    crc_ok_nxt = crc_ok_r;
    crc_nxt    = crc_r;
    if (at_hdr0) begin
      hdr_ok_nxt = (rx_byte == rfltm_pkg::HDR_BYTE0);
      crc_nxt    = rfltm_pkg::CRC_INIT;
    end
    if (at_hdr1) begin
      hdr_ok_nxt = hdr_ok_r && (rx_byte == rfltm_pkg::HDR_BYTE1);
    end
    if (at_pay) begin
      crc_nxt = rfltm_pkg::crc8_byte(crc_r, rx_byte);
    end
    if (at_crc) begin
      crc_ok_nxt = (crc_r == rx_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hdr_ok_r <= 1'b0;
      crc_ok_r <= 1'b0;
      crc_r    <= rfltm_pkg::CRC_INIT;
    end else if (byte_en) begin
      pos_r    <= pos_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      crc_ok_r <= crc_ok_nxt;
      crc_r    <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en && at_pay) begin
      pay_r[pay_off[2:0]] <= rx_byte;
    end
  end

  // the last byte is never a payload byte, so the stored payload is complete
  assign frm.done    = byte_en && last_pos;
  assign frm.good    = hdr_ok_r && crc_ok_nxt;
  assign frm.payload = pay_r;

endmodule

### src/rfltm_map.sv
`timescale 1ns / 1ps

module rfltm_map (
  input  rfltm_pkg::payload_t  payload,
  input  logic [5:0]           min_throttle,
  output rfltm_pkg::thr_arr_t  thr
);

  logic [3:0][15:0] raw;
  logic [3:0][9:0]  vc;
  logic [3:0][9:0]  vm1;
  logic [3:0][11:0] sum;

  // (v-1)*1999/999 equals 2*(v-1), plus one only at v = 1000
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      raw[i] = payload[16*i +: 16];
      vc[i]  = (raw[i] > 16'(rfltm_pkg::THR_CLAMP)) ? rfltm_pkg::THR_CLAMP : raw[i][9:0];
      vm1[i] = vc[i] - 10'd1;
      sum[i] = 12'({vm1[i], 1'b0}) + 12'(vc[i] == rfltm_pkg::THR_CLAMP) + 12'(min_throttle);
      if (vc[i] == 10'd0) begin
        thr[i] = '0;
      end else if (sum[i][11]) begin
        thr[i] = rfltm_pkg::THR_SAT;
      end else begin
        thr[i] = sum[i][10:0];
      end
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAME_LEN    = 11;
  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_CYCLES = 4;
  localparam int ADDR_W       = rfltm_pkg::CFG_AW;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum int {
    FLAW_NONE,
    FLAW_HDR0,
    FLAW_HDR1,
    FLAW_CRC,
    FLAW_PAYLOAD
  } frame_flaw_t;

  typedef struct packed {
    rfltm_pkg::thr_arr_t  thr;
    logic                 strobe;
    logic                 link;
    rfltm_pkg::frame_st_t status;
    logic [31:0]          iv_min;
    logic [31:0]          iv_max;
  } motor_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              in_valid;
  logic              in_stall;
  logic              in_command;
  logic [7:0]        in_rx_byte;
  logic [31:0]       in_now_ms;
  logic              out_valid;
  logic              out_stall;
  logic [10:0]       out_throttle_0;
  logic [10:0]       out_throttle_1;
  logic [10:0]       out_throttle_2;
  logic [10:0]       out_throttle_3;
  logic              out_write_strobe;
  logic              out_link_up;
  logic [1:0]        out_frame_status;
  logic [31:0]       out_interval_min;
  logic [31:0]       out_interval_max;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // predicted block state
  logic [7:0]          rx_frame [FRAME_LEN];
  int                  rx_pos;
  rfltm_pkg::payload_t held_payload;
  logic                link_state;
  logic                payload_fresh;
  logic [31:0]         last_frame_ms;
  logic [31:0]         min_gap_ms;
  logic [31:0]         max_gap_ms;
  rfltm_pkg::thr_arr_t motor_cmd;
  logic                cfg_armed;
  logic [15:0]         cfg_timeout;
  logic [5:0]          cfg_min_thr;

  motor_result_t expected_results [$];
  logic [31:0]   clock_ms;
  int            items_sent;
  int            fail_count;
  int            tx_idle_pct;
  int            rx_stall_pct;
  int            hold_requests;

  rc_frame_link_throttle_map_top #(
    .FRAME_BYTES(FRAME_LEN)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_rx_byte      (in_rx_byte),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_throttle_0  (out_throttle_0),
    .out_throttle_1  (out_throttle_1),
    .out_throttle_2  (out_throttle_2),
    .out_throttle_3  (out_throttle_3),
    .out_write_strobe(out_write_strobe),
    .out_link_up     (out_link_up),
    .out_frame_status(out_frame_status),
    .out_interval_min(out_interval_min),
    .out_interval_max(out_interval_max),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CRC-8, poly 0x31, MSB first, over the eight payload bytes in link order
  function automatic logic [7:0] crc8_over(input rfltm_pkg::payload_t body);
    logic [7:0] c;
    c = rfltm_pkg::CRC_INIT;
    for (int j = 0; j < rfltm_pkg::PAY_BYTES; j++) begin
      c = c ^ body[8*j +: 8];
      for (int k = 0; k < 8; k++) begin
        c = c[7] ? ({c[6:0], 1'b0} ^ rfltm_pkg::CRC_POLY) : {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic rfltm_pkg::thr_t scale_channel(input logic [15:0] raw);
    int unsigned v;
    int unsigned r;
    v = (raw > rfltm_pkg::THR_CLAMP) ? 32'(rfltm_pkg::THR_CLAMP) : 32'(raw);
    if (v == 0) return '0;
    r = 32'(cfg_min_thr) + (v - 1) * 1999 / 999;
    return (r > rfltm_pkg::THR_SAT) ? rfltm_pkg::THR_SAT : rfltm_pkg::thr_t'(r);
  endfunction

  function automatic motor_result_t predict_item(input logic cmd, input logic [7:0] rx,
                                                 input logic [31:0] now);
    motor_result_t       res;
    rfltm_pkg::payload_t body;
    logic                good;
    logic [31:0]         gap;
    res.status = rfltm_pkg::FST_NONE;
    res.strobe = 1'b0;
    if (cmd == CMD_BYTE) begin
      rx_frame[rx_pos] = rx;
      rx_pos++;
      if (rx_pos >= FRAME_LEN) begin
        for (int j = 0; j < rfltm_pkg::PAY_BYTES; j++)
          body[8*j +: 8] = rx_frame[rfltm_pkg::POS_PAY_LO + j];
        good = rx_frame[rfltm_pkg::POS_HDR0] == rfltm_pkg::HDR_BYTE0 &&
               rx_frame[rfltm_pkg::POS_HDR1] == rfltm_pkg::HDR_BYTE1 &&
               crc8_over(body) == rx_frame[rfltm_pkg::POS_CRC];
        rx_pos = 0;
        res.status = good ? rfltm_pkg::FST_GOOD : rfltm_pkg::FST_BAD;
        if (good) begin
          // the frame that brings the link up latches data but is not fresh
          if (link_state) begin
            gap = now - last_frame_ms;
            payload_fresh = 1'b1;
            if (gap > max_gap_ms) max_gap_ms = gap;
            if (gap < min_gap_ms) min_gap_ms = gap;
          end
          held_payload  = body;
          last_frame_ms = now;
          link_state    = 1'b1;
        end else begin
          link_state = 1'b0;
        end
      end
    end else begin
      if (link_state && (now - last_frame_ms) > 32'(cfg_timeout)) link_state = 1'b0;
      if (link_state && cfg_armed) begin
        if (payload_fresh) begin
          payload_fresh = 1'b0;
          for (int i = 0; i < 4; i++) motor_cmd[i] = scale_channel(held_payload[16*i +: 16]);
          res.strobe = 1'b1;
        end
      end else begin
        motor_cmd  = '0;
        res.strobe = 1'b1;
      end
    end
    res.thr    = motor_cmd;
    res.link   = link_state;
    res.iv_min = min_gap_ms;
    res.iv_max = max_gap_ms;
    return res;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_delay();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(0, cfg_timeout);
    if (r < 80) return 32'(cfg_timeout);
    if (r < 88) return 32'(cfg_timeout) + 1;
    if (r < 95) return $urandom_range(0, 20);
    return $urandom;
  endfunction

  function automatic rfltm_pkg::payload_t pick_channels();
    rfltm_pkg::payload_t p;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(9))
        0:       p[16*i +: 16] = 16'd0;
        1:       p[16*i +: 16] = 16'd1;
        2:       p[16*i +: 16] = 16'd1000;
        3:       p[16*i +: 16] = 16'($urandom_range(1001, 65535));
        4:       p[16*i +: 16] = 16'd999;
        default: p[16*i +: 16] = 16'($urandom_range(0, 1000));
      endcase
    end
    return p;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_item(input logic cmd, input logic [7:0] rx);
    motor_result_t res;
    int            gap;
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_rx_byte <= rx;
    in_now_ms  <= clock_ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_item(cmd, rx, clock_ms);
    expected_results.push_back(res);
    items_sent++;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      gap = pick_gap();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 8'($urandom));
  endtask

  // pad with noise bytes until the next byte starts a frame
  task automatic align_to_frame();
    while (rx_pos != 0) send_item(CMD_BYTE, 8'($urandom));
  endtask

  task automatic send_frame(input rfltm_pkg::payload_t chans, input frame_flaw_t flaw);
    logic [7:0] bytes [FRAME_LEN];
    logic [7:0] flip;
    flip = 8'($urandom_range(1, 255));
    bytes[rfltm_pkg::POS_HDR0] = rfltm_pkg::HDR_BYTE0;
    bytes[rfltm_pkg::POS_HDR1] = rfltm_pkg::HDR_BYTE1;
    for (int j = 0; j < rfltm_pkg::PAY_BYTES; j++)
      bytes[rfltm_pkg::POS_PAY_LO + j] = chans[8*j +: 8];
    bytes[rfltm_pkg::POS_CRC] = crc8_over(chans);
    case (flaw)
      FLAW_HDR0:    bytes[rfltm_pkg::POS_HDR0] ^= flip;
      FLAW_HDR1:    bytes[rfltm_pkg::POS_HDR1] ^= flip;
      FLAW_CRC:     bytes[rfltm_pkg::POS_CRC] ^= flip;
      FLAW_PAYLOAD:
        bytes[rfltm_pkg::POS_PAY_LO + $urandom_range(rfltm_pkg::PAY_BYTES - 1)] ^= flip;
      default: ;
    endcase
    for (int i = 0; i < FRAME_LEN; i++) begin
      clock_ms += $urandom_range(0, 1);
      send_item(CMD_BYTE, bytes[i]);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input rfltm_pkg::reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      rfltm_pkg::REG_ARMED:   cfg_armed   = val[0];
      rfltm_pkg::REG_TIMEOUT: cfg_timeout = val[15:0];
      rfltm_pkg::REG_MIN_THR: cfg_min_thr = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic armed, input logic [15:0] tmo, input logic [5:0] min_thr);
    write_reg(rfltm_pkg::REG_ARMED, 32'(armed));
    write_reg(rfltm_pkg::REG_TIMEOUT, 32'(tmo));
    write_reg(rfltm_pkg::REG_MIN_THR, 32'(min_thr));
  endtask

  task automatic run_traffic(input int n_items);
    int stop_at;
    int r;
    int k;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 55) begin
        align_to_frame();
        clock_ms += pick_delay();
        send_frame(pick_channels(), FLAW_NONE);
        if ($urandom_range(1)) begin
          clock_ms += $urandom_range(0, 5);
          send_tick();
        end
      end else if (r < 72) begin
        clock_ms += pick_delay();
        send_tick();
      end else if (r < 85) begin
        align_to_frame();
        clock_ms += pick_delay();
        send_frame(pick_channels(),
                   frame_flaw_t'($urandom_range(int'(FLAW_HDR0), int'(FLAW_PAYLOAD))));
      end else begin
        // misalign the stream on purpose
        k = $urandom_range(1, 4);
        repeat (k) send_item(CMD_BYTE, 8'($urandom));
      end
    end
  endtask

  task automatic test_directed();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_config(1'b1, 16'd100, 6'd63);
    clock_ms = '1;
    send_frame({16'hFFFF, 16'd1000, 16'd1, 16'd0}, FLAW_NONE);
    clock_ms += 20;
    send_frame({16'd1001, 16'd999, 16'd1000, 16'd1}, FLAW_NONE);
    send_tick();
    send_tick();
    clock_ms += 101;
    send_tick();
    wait_idle();
  endtask

  task automatic test_default_settings();
    tx_idle_pct  = 25;
    rx_stall_pct = 25;
    set_config(1'b1, rfltm_pkg::TIMEOUT_RST, rfltm_pkg::MIN_THR_RST);
    run_traffic(300);
    wait_idle();
  endtask

  task automatic test_disarmed();
    tx_idle_pct  = 15;
    rx_stall_pct = 40;
    set_config(1'b0, 16'hFFFF, 6'd0);
    run_traffic(200);
    wait_idle();
  endtask

  task automatic test_timeout_extremes();
    tx_idle_pct  = 20;
    rx_stall_pct = 10;
    set_config(1'b1, 16'd0, 6'd63);
    run_traffic(200);
    wait_idle();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_config(1'b1, 16'hFFFF, 6'd63);
    run_traffic(200);
    wait_idle();
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      tx_idle_pct  = $urandom_range(0, 50);
      rx_stall_pct = $urandom_range(0, 50);
      set_config(1'b1, 16'($urandom_range(0, 300)), 6'($urandom_range(0, 63)));
      run_traffic(120);
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 10;
    set_config(1'b1, rfltm_pkg::TIMEOUT_RST, rfltm_pkg::MIN_THR_RST);
    hold_requests++;
    run_traffic(120);
    wait_idle();
  endtask

  // receiver: random stalls, plus a long hold whenever one is requested
  initial begin
    int holds_served;
    int len;
    holds_served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests > holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        for (int k = 0; k < LONG_HOLD; k++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct) begin
        len = pick_gap();
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    motor_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("throttle_0", 32'(want.thr[0]), 32'(out_throttle_0));
        check_field("throttle_1", 32'(want.thr[1]), 32'(out_throttle_1));
        check_field("throttle_2", 32'(want.thr[2]), 32'(out_throttle_2));
        check_field("throttle_3", 32'(want.thr[3]), 32'(out_throttle_3));
        check_field("write_strobe", 32'(want.strobe), 32'(out_write_strobe));
        check_field("link_up", 32'(want.link), 32'(out_link_up));
        check_field("frame_status", 32'(want.status), 32'(out_frame_status));
        check_field("interval_min", want.iv_min, out_interval_min);
        check_field("interval_max", want.iv_max, out_interval_max);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_BYTE;
    in_rx_byte <= '0;
    in_now_ms  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    rx_pos        = 0;
    held_payload  = '0;
    link_state    = 1'b0;
    payload_fresh = 1'b0;
    last_frame_ms = '0;
    min_gap_ms    = '1;
    max_gap_ms    = '0;
    motor_cmd     = '0;
    cfg_armed     = 1'b0;
    cfg_timeout   = rfltm_pkg::TIMEOUT_RST;
    cfg_min_thr   = rfltm_pkg::MIN_THR_RST;
    clock_ms      = '0;
    items_sent    = 0;
    fail_count    = 0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_requests = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_default_settings();
    test_disarmed();
    test_timeout_extremes();
    test_random_settings();
    test_backpressure();

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
src/rfltm_pkg.sv
src/rfltm_regs.sv
src/rfltm_frame_rx.sv
src/rfltm_map.sv
src/rc_frame_link_throttle_map_top.sv
bench/tb_top.sv
